// ----- rtl/arp_address_conflict_detector_core_macros.svh -----
// assertion helpers for the conflict detector
`ifndef ARP_ADDRESS_CONFLICT_DETECTOR_CORE_MACROS_SVH
`define ARP_ADDRESS_CONFLICT_DETECTOR_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define ACD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ACD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/acd_pkg.sv -----
// ---------------------------------------------------------------------------
// acd_pkg
// shared types and constants of the address conflict detector
// ---------------------------------------------------------------------------
package acd_pkg;

  localparam int unsigned TICK_BITS      = 16;
  localparam int unsigned CNT_BITS       = 17;
  localparam int unsigned PROBE_COUNT    = 3;
  localparam int unsigned ANNOUNCE_COUNT = 3;
  localparam logic [31:0] LFSR_MASK      = 32'h8020_0003;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_ANNOUNCE = 3'd3;
  localparam logic [2:0] OP_PACKET   = 3'd4;
  localparam logic [2:0] OP_LINKDOWN = 3'd5;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PROBE = 2'd1;
  localparam logic [1:0] PH_ANN   = 2'd2;
  localparam logic [1:0] PH_DOWN  = 2'd3;

  localparam logic [1:0] SEND_NONE  = 2'd0;
  localparam logic [1:0] SEND_PROBE = 2'd1;
  localparam logic [1:0] SEND_ANN   = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_READY    = 3'd1;
  localparam logic [2:0] EV_USED     = 3'd2;
  localparam logic [2:0] EV_CONFLICT = 3'd3;
  localparam logic [2:0] EV_DEFENDED = 3'd4;
  localparam logic [2:0] EV_DOWN     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_BADCFG   = 3'd3;
  localparam logic [2:0] ST_SHUTDOWN = 3'd4;
  localparam logic [2:0] ST_NETDOWN  = 3'd5;
  localparam logic [2:0] ST_IOERR    = 3'd6;

  localparam logic [1:0] DEF_NEVER   = 2'd0;
  localparam logic [1:0] DEF_ONCE    = 2'd1;
  localparam logic [1:0] DEF_ALWAYS  = 2'd2;
  localparam logic [1:0] DEF_INVALID = 2'd3;

  localparam logic [2:0] REG_OWN_IP    = 3'd0;
  localparam logic [2:0] REG_OWN_MAC   = 3'd1;
  localparam logic [2:0] REG_SEED      = 3'd2;
  localparam logic [2:0] REG_PWAIT     = 3'd3;
  localparam logic [2:0] REG_PMIN      = 3'd4;
  localparam logic [2:0] REG_PMAX      = 3'd5;
  localparam logic [2:0] REG_AWAIT     = 3'd6;
  localparam logic [2:0] REG_DINTERVAL = 3'd7;

  // schedule request: base plus lfsr mod jitter
  typedef enum logic [1:0] {
    SCH_NONE  = 2'd0,
    SCH_START = 2'd1,
    SCH_PROBE = 2'd2,
    SCH_FIXED = 2'd3
  } sch_t;

  // controller -> datapath
  typedef struct packed {
    logic eval;
    logic div_start;
    logic div_step;
    logic commit;
  } acd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } acd_sts_t;

endpackage

// ----- rtl/arp_address_conflict_detector_core.sv -----
// flow: an accepted word goes through eval, then the 32-step divider when a random
// delay is drawn, then commit into the registered result (held while out_tready is low)
// one word at a time: a new word is taken only once the last result is committed
// reset: synchronous active-low rst_n; phase idle, timer disarmed, lfsr 1,
// registers at their default values
// ---------------------------------------------------------------------------
// arp_address_conflict_detector_core
// ipv4 address conflict probe/announce/defend engine
// ---------------------------------------------------------------------------
module arp_address_conflict_detector_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], defend_mode[4:3], arp_is_request[5], sender_ip[37:6],
  // target_ip[69:38], sender_mac[117:70], zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // send_kind[1:0], event_res[4:2], status[7:5], phase_now[9:8], zero pad
  output logic [15:0]  out_tdata
);

  acd_pkg::acd_cmd_t cmd;
  acd_pkg::acd_sts_t sts;
  logic              in_fire;
  logic              out_free;
  logic [9:0]        word;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;

  acd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  acd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_fire          (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_fire           (in_fire),
    .in_op             (in_tdata[2:0]),
    .in_defend_mode    (in_tdata[4:3]),
    .in_arp_is_request (in_tdata[5]),
    .in_sender_ip      (in_tdata[37:6]),
    .in_target_ip      (in_tdata[69:38]),
    .in_sender_mac     (in_tdata[117:70]),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_word          (word)
  );

  assign out_tdata = {6'd0, word};

endmodule

// ----- rtl/acd_ctrl.sv -----
// ---------------------------------------------------------------------------
// acd_ctrl
// sequencer: take word, evaluate, optional divide, commit, present result
// ---------------------------------------------------------------------------
module acd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  input  acd_pkg::acd_sts_t sts,
  output logic              in_ready,
  output acd_pkg::acd_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_DIV    = 5'b00100,
    S_COMMIT = 5'b01000,
    S_WAIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`include "arp_address_conflict_detector_core_macros.svh"

  `ACD_ASSERT_NXT(a_fire_eval, clk, rst_n, in_fire, state_r == S_EVAL, "accept not followed by eval")
  `ACD_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.eval, cmd.div_step, cmd.commit}), "more than one command at once")
  `ACD_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !cmd.commit && !cmd.div_step, "ready while busy")

endmodule

// ----- rtl/acd_datapath.sv -----
// ---------------------------------------------------------------------------
// acd_datapath
// config registers, protocol state, lfsr, bit-serial divider, result word
// ---------------------------------------------------------------------------
module acd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_fire,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_fire,
  input  logic [2:0]        in_op,
  input  logic [1:0]        in_defend_mode,
  input  logic              in_arp_is_request,
  input  logic [31:0]       in_sender_ip,
  input  logic [31:0]       in_target_ip,
  input  logic [47:0]       in_sender_mac,
  input  acd_pkg::acd_cmd_t cmd,
  output acd_pkg::acd_sts_t sts,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [9:0]        out_word
);

  localparam logic [acd_pkg::TICK_BITS-1:0] SINCE_MAX = '1;

  // configuration
  logic [31:0] own_ip_r, seed_r;
  logic [47:0] own_mac_r;
  logic [15:0] pwait_r, pmin_r, pmax_r, await_r, dint_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
      seed_r    <= 32'd1;
      pwait_r   <= 16'd1000;
      pmin_r    <= 16'd1000;
      pmax_r    <= 16'd3000;
      await_r   <= 16'd2000;
      dint_r    <= 16'd10000;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        acd_pkg::REG_OWN_IP:    own_ip_r  <= cfg_data[31:0];
        acd_pkg::REG_OWN_MAC:   own_mac_r <= cfg_data[47:0];
        acd_pkg::REG_SEED:      seed_r    <= cfg_data[31:0];
        acd_pkg::REG_PWAIT:     pwait_r   <= cfg_data[15:0];
        acd_pkg::REG_PMIN:      pmin_r    <= cfg_data[15:0];
        acd_pkg::REG_PMAX:      pmax_r    <= cfg_data[15:0];
        acd_pkg::REG_AWAIT:     await_r   <= cfg_data[15:0];
        acd_pkg::REG_DINTERVAL: dint_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic [2:0]  op_r;
  logic [1:0]  mode_r;
  logic        req_r;
  logic [31:0] sip_r, tip_r;
  logic [47:0] smac_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_op;
      mode_r <= in_defend_mode;
      req_r  <= in_arp_is_request;
      sip_r  <= in_sender_ip;
      tip_r  <= in_target_ip;
      smac_r <= in_sender_mac;
    end
  end

  // protocol state
  logic [1:0]                    phase_r, phase_nxt;
  logic [1:0]                    round_r, round_nxt;
  logic [1:0]                    policy_r, policy_nxt;
  logic                          armed_r, armed_nxt;
  logic [acd_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [acd_pkg::TICK_BITS-1:0] since_r, since_nxt;
  logic [31:0]                   lfsr_r, lfsr_nxt;

  // evaluation results held until commit
  logic [1:0]  send_r, send_nxt;
  logic [2:0]  ev_r, ev_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] jit_r, jit_nxt;
  logic        sch_r, sch_nxt;

  logic [31:0] lfsr_src, lfsr_step;
  logic        load_seed;

  always_comb begin
    phase_nxt  = phase_r;
    round_nxt  = round_r;
    policy_nxt = policy_r;
    armed_nxt  = armed_r;
    cnt_nxt    = cnt_r;
    since_nxt  = since_r;
    send_nxt   = acd_pkg::SEND_NONE;
    ev_nxt     = acd_pkg::EV_NONE;
    st_nxt     = acd_pkg::ST_OK;
    base_nxt   = '0;
    jit_nxt    = '0;
    sch_nxt    = 1'b0;
    load_seed  = 1'b0;
    case (op_r)
      acd_pkg::OP_TICK: begin
        if (since_r != SINCE_MAX) since_nxt = since_r + 1'b1;
        if (armed_r) begin
          if (cnt_r > acd_pkg::CNT_BITS'(1)) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            armed_nxt = 1'b0;
            cnt_nxt   = '0;
            if (phase_r == acd_pkg::PH_PROBE) begin
              if (32'(round_r) >= acd_pkg::PROBE_COUNT) begin
                ev_nxt = acd_pkg::EV_READY;
              end else begin
                send_nxt  = acd_pkg::SEND_PROBE;
                round_nxt = round_r + 1'b1;
                sch_nxt   = 1'b1;
                if (32'(round_nxt) >= acd_pkg::PROBE_COUNT) begin
                  base_nxt = await_r;
                end else begin
                  base_nxt = pmin_r;
                  jit_nxt  = (pmax_r > pmin_r) ? pmax_r - pmin_r : '0;
                end
              end
            end else if (phase_r == acd_pkg::PH_ANN) begin
              send_nxt = acd_pkg::SEND_ANN;
              if (round_r != 2'd3) round_nxt = round_r + 1'b1;
              if (32'(round_nxt) < acd_pkg::ANNOUNCE_COUNT) begin
                sch_nxt  = 1'b1;
                base_nxt = await_r;
              end
            end
          end
        end
      end
      acd_pkg::OP_START: begin
        if (phase_r != acd_pkg::PH_IDLE) begin
          st_nxt = acd_pkg::ST_BUSY;
        end else if (own_ip_r == '0 || own_mac_r == '0) begin
          st_nxt = acd_pkg::ST_BADCFG;
        end else begin
          load_seed  = 1'b1;
          sch_nxt    = 1'b1;
          jit_nxt    = pwait_r;
          phase_nxt  = acd_pkg::PH_PROBE;
          policy_nxt = acd_pkg::DEF_NEVER;
          round_nxt  = '0;
          since_nxt  = SINCE_MAX;
        end
      end
      acd_pkg::OP_STOP: begin
        phase_nxt  = acd_pkg::PH_IDLE;
        round_nxt  = '0;
        policy_nxt = acd_pkg::DEF_NEVER;
        since_nxt  = SINCE_MAX;
        armed_nxt  = 1'b0;
        cnt_nxt    = '0;
      end
      acd_pkg::OP_ANNOUNCE: begin
        if (mode_r == acd_pkg::DEF_INVALID) begin
          st_nxt = acd_pkg::ST_INVALID;
        end else if (phase_r == acd_pkg::PH_IDLE) begin
          st_nxt = acd_pkg::ST_SHUTDOWN;
        end else if (phase_r == acd_pkg::PH_DOWN) begin
          st_nxt = acd_pkg::ST_NETDOWN;
        end else begin
          sch_nxt    = 1'b1;
          phase_nxt  = acd_pkg::PH_ANN;
          policy_nxt = mode_r;
          round_nxt  = '0;
        end
      end
      acd_pkg::OP_PACKET: begin
        if (smac_r != own_mac_r &&
            ((sip_r == '0 && tip_r == own_ip_r && req_r) || sip_r == own_ip_r)) begin
          if (phase_r == acd_pkg::PH_PROBE) begin
            armed_nxt = 1'b0;
            cnt_nxt   = '0;
            ev_nxt    = acd_pkg::EV_USED;
          end else if (phase_r == acd_pkg::PH_ANN) begin
            // soft conflict (probe for our address) is ignored here
            if (sip_r == own_ip_r &&
                !(sip_r == '0 && tip_r == own_ip_r && req_r)) begin
              if (policy_r == acd_pkg::DEF_NEVER) begin
                armed_nxt = 1'b0;
                cnt_nxt   = '0;
                ev_nxt    = acd_pkg::EV_CONFLICT;
              end else if (since_r > dint_r) begin
                send_nxt  = acd_pkg::SEND_ANN;
                since_nxt = '0;
                ev_nxt    = acd_pkg::EV_DEFENDED;
              end else if (policy_r == acd_pkg::DEF_ONCE) begin
                armed_nxt = 1'b0;
                cnt_nxt   = '0;
                ev_nxt    = acd_pkg::EV_CONFLICT;
              end else begin
                ev_nxt = acd_pkg::EV_DEFENDED;
              end
            end
          end else begin
            st_nxt = acd_pkg::ST_IOERR;
          end
        end
      end
      acd_pkg::OP_LINKDOWN: begin
        if (phase_r == acd_pkg::PH_PROBE || phase_r == acd_pkg::PH_ANN) begin
          armed_nxt = 1'b0;
          cnt_nxt   = '0;
          phase_nxt = acd_pkg::PH_DOWN;
          round_nxt = '0;
          ev_nxt    = acd_pkg::EV_DOWN;
        end
      end
      default: st_nxt = acd_pkg::ST_INVALID;
    endcase
  end

  assign lfsr_src  = load_seed ? ((seed_r != '0) ? seed_r : 32'd1) : lfsr_r;
  assign lfsr_step = (lfsr_src >> 1) ^ (lfsr_src[0] ? acd_pkg::LFSR_MASK : 32'd0);

  // restoring divider, one quotient bit per cycle: rem = lfsr mod jitter
  logic [16:0] rem_r;
  logic [31:0] dvd_r;
  logic [5:0]  dcnt_r;
  logic [16:0] rem_sh;
  logic        div_done;

  assign rem_sh   = {rem_r[15:0], dvd_r[31]};
  assign div_done = (dcnt_r == 6'd32);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= '0;
      dvd_r  <= lfsr_step;
      dcnt_r <= '0;
    end else if (cmd.div_step && !div_done) begin
      rem_r  <= (rem_sh >= {1'b0, jit_r}) ? rem_sh - {1'b0, jit_r} : rem_sh;
      dvd_r  <= {dvd_r[30:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  assign sts.need_div = sch_nxt && (jit_nxt != '0);
  assign sts.div_done = div_done;

  logic [16:0] sched_sum;
  assign sched_sum = {1'b0, base_r} + ((jit_r != '0) ? rem_r : 17'd0);

  // output register
  logic [9:0] word_r;
  logic       ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= acd_pkg::PH_IDLE;
      round_r  <= '0;
      policy_r <= acd_pkg::DEF_NEVER;
      armed_r  <= 1'b0;
      cnt_r    <= '0;
      since_r  <= SINCE_MAX;
      lfsr_r   <= 32'd1;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.eval) begin
        phase_r  <= phase_nxt;
        round_r  <= round_nxt;
        policy_r <= policy_nxt;
        armed_r  <= armed_nxt;
        cnt_r    <= cnt_nxt;
        since_r  <= since_nxt;
        if (sch_nxt && jit_nxt != '0) lfsr_r <= lfsr_step;
        else if (load_seed)           lfsr_r <= lfsr_src;
      end
      if (cmd.commit) begin
        ovalid_r <= 1'b1;
        if (sch_r) begin
          armed_r <= 1'b1;
          cnt_r   <= (sched_sum == '0) ? 17'd1 : sched_sum;
        end
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      send_r <= send_nxt;
      ev_r   <= ev_nxt;
      st_r   <= st_nxt;
      base_r <= base_nxt;
      jit_r  <= jit_nxt;
      sch_r  <= sch_nxt;
    end
    if (cmd.commit) word_r <= {phase_r, st_r, ev_r, send_r};
  end

  assign out_tvalid = ovalid_r;
  assign out_word   = word_r;

`include "arp_address_conflict_detector_core_macros.svh"

  `ACD_ASSERT_NXT(a_commit_valid, clk, rst_n, cmd.commit, out_tvalid, "commit without result")
  `ACD_ASSERT_IMP(a_armed_nz, clk, rst_n, armed_r, cnt_r != '0, "armed timer at zero")
  `ACD_ASSERT_IMP(a_div_range, clk, rst_n, div_done && jit_r != '0, rem_r < {1'b0, jit_r}, "remainder out of range")

endmodule
